// ===== sv/sbpb_pkg.sv =====
`default_nettype none
package sbpb_pkg;

   // field widths of one request beat and one response beat
   localparam int OP_W     = 3;
   localparam int REG_W    = 10;
   localparam int NOW_W    = 32;
   localparam int WANT_W   = 4;
   localparam int PORTS_W  = 4;
   localparam int RLEFT_W  = 8;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 8;

   // control and status registers
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] CSR_FIRST_REG   = 2'd0;
   localparam logic [1:0] CSR_READ_PORTS  = 2'd1;
   localparam logic [1:0] CSR_WRITE_PORTS = 2'd2;

   localparam logic [PORTS_W-1:0] READ_PORTS_RESET  = 4'd2;
   localparam logic [PORTS_W-1:0] WRITE_PORTS_RESET = 4'd1;

   typedef enum logic [OP_W-1:0] {
      OP_RESERVE     = 3'd0,
      OP_MARK_DONE   = 3'd1,
      OP_QUERY_VALID = 3'd2,
      OP_QUERY_BUSY  = 3'd3,
      OP_CLEAR_ALL   = 3'd4,
      OP_READ_PORTS  = 3'd5,
      OP_WRITE_PORT  = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_NOVAL = 2'd0,
      ST_WAIT  = 2'd1,
      ST_DONE  = 2'd2
   } status_type;

   typedef struct packed {
      logic       accessed;
      status_type status;
   } entry_type;

   // table update from the execute stage
   typedef struct packed {
      logic      we;
      logic      clr;
      entry_type data;
   } tbl_wr_type;

   typedef struct packed {
      logic answer;
      logic error;
   } budget_res_type;

endpackage
`default_nettype wire

// ===== sv/register_scoreboard_with_port_budget.sv =====
`default_nettype none
// path: a request beat is registered into the execute stage and its response beat into
//   the output register, where it waits until rsp_tready takes it
// throughput: one request beat per cycle while rsp_tready is high; a stalled response
//   holds the execute stage and request beats wait until it drains
// reset: synchronous; all entries read as no value and not accessed, stamps zero,
//   budgets and port counts at their register reset values, no clearing pass
module register_scoreboard_with_port_budget #(
   parameter int NUM_REGS = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // tdata: reg_num[9:0], now[41:10], read_ports_wanted[45:42], zero fill[47:46]
   input  wire logic [sbpb_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // tuser: operation[2:0]
   input  wire logic [sbpb_pkg::OP_W-1:0]           req_tuser,
   // response channel
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // tdata: answer[0], zero fill[7:1]
   output logic [sbpb_pkg::RSP_TDATA_W-1:0]         rsp_tdata,
   // tuser: error[0]
   output logic                                     rsp_tuser,
   // configuration port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [sbpb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [sbpb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sbpb_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                     csr_pready
);

   localparam int IdxW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   // configuration registers
   logic [sbpb_pkg::REG_W-1:0]   first_reg_ff;
   logic [sbpb_pkg::PORTS_W-1:0] rpc_ff;
   logic [sbpb_pkg::PORTS_W-1:0] wpc_ff;
   logic                         csr_wr;

   // execute stage
   logic                         s1_valid_ff;
   sbpb_pkg::op_type             s1_op_ff;
   logic [sbpb_pkg::NOW_W-1:0]   s1_now_ff;
   logic [sbpb_pkg::WANT_W-1:0]  s1_want_ff;
   logic [IdxW-1:0]              s1_idx_ff;
   logic                         s1_inrange_ff;
   logic                         s1_fire;

   // output register
   logic                         rsp_valid_ff;
   logic                         rsp_answer_ff;
   logic                         rsp_error_ff;

   // decode of the incoming beat
   logic                         req_beat;
   logic [sbpb_pkg::REG_W:0]     diff;
   logic                         in_range;
   logic [IdxW-1:0]              in_idx;

   sbpb_pkg::entry_type          entry;
   sbpb_pkg::entry_type          entry_nxt;
   sbpb_pkg::tbl_wr_type         tbl_wr;
   sbpb_pkg::budget_res_type     bres;
   logic                         ex_answer;
   logic                         ex_error;
   logic                         ex_we;
   logic                         ex_clr;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_reg_ff <= '0;
         rpc_ff       <= sbpb_pkg::READ_PORTS_RESET;
         wpc_ff       <= sbpb_pkg::WRITE_PORTS_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            sbpb_pkg::CSR_FIRST_REG:   first_reg_ff <= csr_pwdata[sbpb_pkg::REG_W-1:0];
            sbpb_pkg::CSR_READ_PORTS:  rpc_ff       <= csr_pwdata[sbpb_pkg::PORTS_W-1:0];
            sbpb_pkg::CSR_WRITE_PORTS: wpc_ff       <= csr_pwdata[sbpb_pkg::PORTS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         sbpb_pkg::CSR_FIRST_REG:   csr_prdata = sbpb_pkg::CSR_DATA_W'(first_reg_ff);
         sbpb_pkg::CSR_READ_PORTS:  csr_prdata = sbpb_pkg::CSR_DATA_W'(rpc_ff);
         sbpb_pkg::CSR_WRITE_PORTS: csr_prdata = sbpb_pkg::CSR_DATA_W'(wpc_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- handshake
   // the execute stage moves on whenever the output register is free or drains
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_beat   = req_tvalid && req_tready;

   // entry index of the requested register, relative to first_reg
   assign diff     = {1'b0, req_tdata[9:0]} - {1'b0, first_reg_ff};
   assign in_range = !diff[sbpb_pkg::REG_W]
                     && ({1'b0, diff[sbpb_pkg::REG_W-1:0]} < (sbpb_pkg::REG_W+1)'(NUM_REGS));
   assign in_idx   = diff[IdxW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_op_ff      <= sbpb_pkg::op_type'(req_tuser);
         s1_idx_ff     <= in_idx;
         s1_inrange_ff <= in_range;
         s1_now_ff     <= req_tdata[41:10];
         s1_want_ff    <= req_tdata[45:42];
      end
   end

   // ---------------------------------------------------------- status table
   sbpb_table #(
      .NUM_REGS (NUM_REGS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_beat),
      .rd_idx   (in_idx),
      .wr       (tbl_wr),
      .wr_idx   (s1_idx_ff),
      .rd_entry (entry)
   );

   // ---------------------------------------------------------- port budgets
   sbpb_budget u_budget (
      .clock            (clock),
      .reset            (reset),
      .fire             (s1_fire),
      .op               (s1_op_ff),
      .now              (s1_now_ff),
      .want             (s1_want_ff),
      .read_port_count  (rpc_ff),
      .write_port_count (wpc_ff),
      .res              (bres)
   );

   // ---------------------------------------------------------- execute
   always_comb begin
      entry_nxt = entry;
      ex_answer = 1'b0;
      ex_error  = 1'b0;
      ex_we     = 1'b0;
      ex_clr    = 1'b0;
      case (s1_op_ff)
         sbpb_pkg::OP_RESERVE: begin
            if (!s1_inrange_ff || entry.status == sbpb_pkg::ST_WAIT) begin
               ex_error = 1'b1;
            end else begin
               entry_nxt.status = sbpb_pkg::ST_WAIT;
               ex_we            = 1'b1;
            end
         end
         sbpb_pkg::OP_MARK_DONE: begin
            if (!s1_inrange_ff || entry.status != sbpb_pkg::ST_WAIT) begin
               ex_error = 1'b1;
            end else begin
               entry_nxt.status = sbpb_pkg::ST_DONE;
               ex_we            = 1'b1;
            end
         end
         sbpb_pkg::OP_QUERY_VALID: begin
            if (!s1_inrange_ff) begin
               ex_error = 1'b1;
            end else if (entry.accessed) begin
               // accessed entry with no value is an illegal state
               ex_error  = (entry.status == sbpb_pkg::ST_NOVAL);
               ex_answer = (entry.status == sbpb_pkg::ST_DONE);
            end else begin
               // first access promotes no value to written
               entry_nxt.accessed = 1'b1;
               if (entry.status == sbpb_pkg::ST_NOVAL) begin
                  entry_nxt.status = sbpb_pkg::ST_DONE;
               end
               ex_we     = 1'b1;
               ex_answer = (entry_nxt.status == sbpb_pkg::ST_DONE);
            end
         end
         sbpb_pkg::OP_QUERY_BUSY: begin
            if (!s1_inrange_ff) begin
               ex_error = 1'b1;
            end else begin
               ex_answer = (entry.status == sbpb_pkg::ST_WAIT);
            end
         end
         sbpb_pkg::OP_CLEAR_ALL: begin
            ex_clr = 1'b1;
         end
         sbpb_pkg::OP_READ_PORTS, sbpb_pkg::OP_WRITE_PORT: begin
            ex_answer = bres.answer;
            ex_error  = bres.error;
         end
         default: begin
         end
      endcase
   end

   // table updates only land when the beat leaves the execute stage
   always_comb begin
      tbl_wr.we   = s1_fire && ex_we;
      tbl_wr.clr  = s1_fire && ex_clr;
      tbl_wr.data = entry_nxt;
   end

   // ---------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_answer_ff <= ex_answer;
         rsp_error_ff  <= ex_error;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(sbpb_pkg::RSP_TDATA_W-1)'(0), rsp_answer_ff};
   assign rsp_tuser  = rsp_error_ff;

   // ---------------------------------------------------------- assertions
   // an error never carries a positive answer
   a_no_answer_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_answer_ff && rsp_error_ff))
      else $error("response carries answer and error together");

   // a new beat only enters the execute stage when the old one leaves
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_beat && s1_valid_ff) |-> s1_fire)
      else $error("execute stage overwritten");

   // a response appears only after the execute stage hands one over
   a_rsp_from_fire: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_fire))
      else $error("response without execute handoff");

   // the table is only written for entries inside the window
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      tbl_wr.we |-> (s1_inrange_ff && !tbl_wr.clr))
      else $error("table write outside the register window");

endmodule
`default_nettype wire

// ===== sv/sbpb_table.sv =====
`default_nettype none
module sbpb_table #(
   parameter int NUM_REGS = 64,
   localparam int IdxW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rd_en,
   input  wire logic [IdxW-1:0]     rd_idx,
   input  wire sbpb_pkg::tbl_wr_type wr,
   input  wire logic [IdxW-1:0]     wr_idx,
   output sbpb_pkg::entry_type      rd_entry
);

   sbpb_pkg::entry_type mem [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   sbpb_pkg::entry_type mem_q_ff;
   sbpb_pkg::entry_type fwd_data_ff;
   logic                fwd_ff;
   logic                vld_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff    <= mem[rd_idx];
         fwd_data_ff <= wr.data;
      end
      if (wr.we) begin
         mem[wr_idx] <= wr.data;
      end
   end

   // valid bits: entry not yet written since reset or clear reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.clr) begin
         valid_ff <= '0;
      end else if (wr.we) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   // bypass for an update landing on the same edge as the read
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr.we && (wr_idx == rd_idx);
         vld_ff <= valid_ff[rd_idx] && !wr.clr;
      end
   end

   always_comb begin
      if (fwd_ff) begin
         rd_entry = fwd_data_ff;
      end else if (vld_ff) begin
         rd_entry = mem_q_ff;
      end else begin
         rd_entry = '0;
      end
   end

endmodule
`default_nettype wire

// ===== sv/sbpb_budget.sv =====
`default_nettype none
module sbpb_budget (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            fire,
   input  wire sbpb_pkg::op_type                op,
   input  wire logic [sbpb_pkg::NOW_W-1:0]      now,
   input  wire logic [sbpb_pkg::WANT_W-1:0]     want,
   input  wire logic [sbpb_pkg::PORTS_W-1:0]    read_port_count,
   input  wire logic [sbpb_pkg::PORTS_W-1:0]    write_port_count,
   output sbpb_pkg::budget_res_type             res
);

   logic [sbpb_pkg::NOW_W-1:0]          rstamp_ff, rstamp_in;
   logic [sbpb_pkg::NOW_W-1:0]          wstamp_ff, wstamp_in;
   logic signed [sbpb_pkg::RLEFT_W-1:0] rleft_ff, rleft_in;
   logic [sbpb_pkg::PORTS_W-1:0]        wleft_ff, wleft_in;
   logic signed [sbpb_pkg::RLEFT_W:0]   rsum;
   logic [sbpb_pkg::PORTS_W-1:0]        wdec;

   always_ff @(posedge clock) begin
      if (reset) begin
         rstamp_ff <= '0;
         wstamp_ff <= '0;
         rleft_ff  <= signed'(sbpb_pkg::RLEFT_W'(sbpb_pkg::READ_PORTS_RESET));
         wleft_ff  <= sbpb_pkg::WRITE_PORTS_RESET;
      end else if (fire) begin
         rstamp_ff <= rstamp_in;
         wstamp_ff <= wstamp_in;
         rleft_ff  <= rleft_in;
         wleft_ff  <= wleft_in;
      end
   end

   always_comb begin
      rstamp_in = rstamp_ff;
      wstamp_in = wstamp_ff;
      rleft_in  = rleft_ff;
      wleft_in  = wleft_ff;
      res       = '0;
      rsum      = {rleft_ff[sbpb_pkg::RLEFT_W-1], rleft_ff}
                - signed'({(sbpb_pkg::RLEFT_W - sbpb_pkg::WANT_W + 1)'(0), want});
      wdec      = (wleft_ff != '0) ? wleft_ff - 1'b1 : '0;
      case (op)
         sbpb_pkg::OP_READ_PORTS: begin
            if (want > read_port_count || now < rstamp_ff) begin
               res.error = 1'b1;
            end else if (now > rstamp_ff) begin
               rstamp_in  = now;
               rleft_in   = signed'(sbpb_pkg::RLEFT_W'(read_port_count - want));
               res.answer = 1'b1;
            end else begin
               // saturate at the most negative budget
               if (rsum[sbpb_pkg::RLEFT_W:sbpb_pkg::RLEFT_W-1] == 2'b10) begin
                  rleft_in = {1'b1, (sbpb_pkg::RLEFT_W-1)'(0)};
               end else begin
                  rleft_in = rsum[sbpb_pkg::RLEFT_W-1:0];
               end
               res.answer = !rleft_in[sbpb_pkg::RLEFT_W-1];
            end
         end
         sbpb_pkg::OP_WRITE_PORT: begin
            if (now < wstamp_ff) begin
               res.error = 1'b1;
            end else if (now > wstamp_ff) begin
               wstamp_in  = now;
               wleft_in   = write_port_count;
               res.answer = 1'b1;
            end else begin
               wleft_in   = wdec;
               res.answer = (wdec != '0);
            end
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== test/tb_register_scoreboard_with_port_budget.sv =====
`default_nettype none
module tb_register_scoreboard_with_port_budget;

   localparam int NUM_REGS    = 64;
   localparam int REG_MAX     = 2**sbpb_pkg::REG_W - 1;
   localparam int STALL_LIMIT = 2000;   // cycles with no beat, no register access
   localparam int DRAIN_CYCLES = 8;     // extra wait once no response is owed
   localparam int RD_FLOOR    = -128;   // read budget saturates here

   // tuser code with no operation behind it, the block answers zeros
   localparam logic [sbpb_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

   // one row of the directed table; answer and error are only used when fixed is set
   typedef struct packed {
      logic [sbpb_pkg::OP_W-1:0]   op;
      logic [sbpb_pkg::REG_W-1:0]  reg_num;
      logic [sbpb_pkg::NOW_W-1:0]  now;
      logic [sbpb_pkg::WANT_W-1:0] want;
      logic                        fixed;
      logic                        answer;
      logic                        error;
   } stim_row_type;

   localparam int NUM_ROWS = 26;
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // fresh entry reads as not busy
      '{sbpb_pkg::OP_QUERY_BUSY,  10'd0,    32'd0, 4'd0,  1'b1, 1'b0, 1'b0},
      // first valid query promotes no value to written, then stays written
      '{sbpb_pkg::OP_QUERY_VALID, 10'd1,    32'd0, 4'd0,  1'b1, 1'b1, 1'b0},
      '{sbpb_pkg::OP_QUERY_VALID, 10'd1,    32'd0, 4'd0,  1'b1, 1'b1, 1'b0},
      // reserve, then reserve again while waiting is refused
      '{sbpb_pkg::OP_RESERVE,     10'd2,    32'd0, 4'd0,  1'b1, 1'b0, 1'b0},
      '{sbpb_pkg::OP_RESERVE,     10'd2,    32'd0, 4'd0,  1'b1, 1'b0, 1'b1},
      '{sbpb_pkg::OP_QUERY_BUSY,  10'd2,    32'd0, 4'd0,  1'b1, 1'b1, 1'b0},
      // first valid query of a waiting entry: not valid, no error
      '{sbpb_pkg::OP_QUERY_VALID, 10'd2,    32'd0, 4'd0,  1'b1, 1'b0, 1'b0},
      '{sbpb_pkg::OP_MARK_DONE,   10'd2,    32'd0, 4'd0,  1'b1, 1'b0, 1'b0},
      // writeback of an entry that is not waiting
      '{sbpb_pkg::OP_MARK_DONE,   10'd2,    32'd0, 4'd0,  1'b1, 1'b0, 1'b1},
      '{sbpb_pkg::OP_QUERY_VALID, 10'd2,    32'd0, 4'd0,  1'b1, 1'b1, 1'b0},
      // table edges and register numbers past the table
      '{sbpb_pkg::OP_RESERVE,     10'd63,   32'd0, 4'd0,  1'b1, 1'b0, 1'b0},
      '{sbpb_pkg::OP_RESERVE,     10'd64,   32'd0, 4'd0,  1'b1, 1'b0, 1'b1},
      '{sbpb_pkg::OP_QUERY_BUSY,  10'd1023, 32'd0, 4'd0,  1'b1, 1'b0, 1'b1},
      '{sbpb_pkg::OP_MARK_DONE,   10'd63,   32'd0, 4'd0,  1'b0, 1'b0, 1'b0},
      '{sbpb_pkg::OP_CLEAR_ALL,   10'd1023, 32'hFFFF_FFFF, 4'd15, 1'b1, 1'b0, 1'b0},
      '{sbpb_pkg::OP_QUERY_BUSY,  10'd2,    32'd0, 4'd0,  1'b0, 1'b0, 1'b0},
      // read budget at the reset stamp: two ports, then overdrawn, then too many
      '{sbpb_pkg::OP_READ_PORTS,  10'd0,    32'd0, 4'd2,  1'b1, 1'b1, 1'b0},
      '{sbpb_pkg::OP_READ_PORTS,  10'd0,    32'd0, 4'd1,  1'b1, 1'b0, 1'b0},
      '{sbpb_pkg::OP_READ_PORTS,  10'd0,    32'd0, 4'd3,  1'b1, 1'b0, 1'b1},
      '{sbpb_pkg::OP_READ_PORTS,  10'd0,    32'd0, 4'd15, 1'b1, 1'b0, 1'b1},
      // one write port at the reset stamp is already spent by the first request
      '{sbpb_pkg::OP_WRITE_PORT,  10'd0,    32'd0, 4'd0,  1'b1, 1'b0, 1'b0},
      '{sbpb_pkg::OP_WRITE_PORT,  10'd0,    32'd5, 4'd0,  1'b1, 1'b1, 1'b0},
      '{sbpb_pkg::OP_WRITE_PORT,  10'd0,    32'd4, 4'd0,  1'b1, 1'b0, 1'b1},
      '{sbpb_pkg::OP_READ_PORTS,  10'd0,    32'd7, 4'd0,  1'b1, 1'b1, 1'b0},
      '{sbpb_pkg::OP_READ_PORTS,  10'd0,    32'd6, 4'd0,  1'b1, 1'b0, 1'b1},
      // unused code with every field at its top
      '{OP_UNUSED,                10'd1023, 32'hFFFF_FFFF, 4'd15, 1'b1, 1'b0, 1'b0}
   };

   // dut ports, all driven to known values from time zero
   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [sbpb_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [sbpb_pkg::OP_W-1:0]        req_tuser = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [sbpb_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tuser;
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [sbpb_pkg::CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [sbpb_pkg::CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [sbpb_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                             csr_pready;

   // shadow of the scoreboard: table, stamps, budgets and register settings
   sbpb_pkg::status_type             entry_status [NUM_REGS];
   logic                             entry_seen   [NUM_REGS];
   logic [sbpb_pkg::NOW_W-1:0]       rd_stamp = '0;
   logic [sbpb_pkg::NOW_W-1:0]       wr_stamp = '0;
   int                               rd_budget = int'(sbpb_pkg::READ_PORTS_RESET);
   logic [sbpb_pkg::PORTS_W-1:0]     wr_budget = sbpb_pkg::WRITE_PORTS_RESET;
   logic [sbpb_pkg::REG_W-1:0]       base_reg = '0;
   logic [sbpb_pkg::PORTS_W-1:0]     rd_ports_set = sbpb_pkg::READ_PORTS_RESET;
   logic [sbpb_pkg::PORTS_W-1:0]     wr_ports_set = sbpb_pkg::WRITE_PORTS_RESET;

   // outcomes still owed by the block, oldest first
   sbpb_pkg::budget_res_type         owed_outcomes [$];

   // directed rows carry their own expected outcome
   bit                               row_fixed = 1'b0;
   sbpb_pkg::budget_res_type         row_fixed_res = '0;

   // stimulus bookkeeping
   longint                           cur_cycle = 0;
   int                               beats_sent = 0;
   bit                               gaps_on = 1'b1;
   int                               calm_tx = 0;
   int                               calm_rx = 0;
   int                               stall_rx = 0;

   // results
   int                               fail_count = 0;
   int                               beats_checked = 0;
   int                               grants_seen = 0;
   int                               errors_seen = 0;
   int                               settings_used = 0;
   int                               quiet_cycles = 0;

   register_scoreboard_with_port_budget #(
      .NUM_REGS(NUM_REGS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #5 clock = ~clock;

   // outcome of one request beat; updates the shadow state like the block does
   function automatic sbpb_pkg::budget_res_type scoreboard_outcome(
         input logic [sbpb_pkg::OP_W-1:0] op,
         input logic [sbpb_pkg::REG_W-1:0] reg_num,
         input logic [sbpb_pkg::NOW_W-1:0] now,
         input logic [sbpb_pkg::WANT_W-1:0] want);
      sbpb_pkg::budget_res_type res;
      int idx;
      res = '0;
      idx = int'(reg_num) - int'(base_reg);
      if (op <= sbpb_pkg::OP_QUERY_BUSY && (idx < 0 || idx >= NUM_REGS)) begin
         // register outside the table window
         res.error = 1'b1;
      end else begin
         case (op)
            sbpb_pkg::OP_RESERVE: begin
               if (entry_status[idx] == sbpb_pkg::ST_WAIT) res.error = 1'b1;
               else entry_status[idx] = sbpb_pkg::ST_WAIT;
            end
            sbpb_pkg::OP_MARK_DONE: begin
               if (entry_status[idx] != sbpb_pkg::ST_WAIT) res.error = 1'b1;
               else entry_status[idx] = sbpb_pkg::ST_DONE;
            end
            sbpb_pkg::OP_QUERY_VALID: begin
               if (entry_seen[idx]) begin
                  if (entry_status[idx] == sbpb_pkg::ST_NOVAL) res.error = 1'b1;
               end else begin
                  // first access: an entry with no value counts as written
                  entry_seen[idx] = 1'b1;
                  if (entry_status[idx] == sbpb_pkg::ST_NOVAL)
                     entry_status[idx] = sbpb_pkg::ST_DONE;
               end
               res.answer = !res.error && entry_status[idx] == sbpb_pkg::ST_DONE;
            end
            sbpb_pkg::OP_QUERY_BUSY: begin
               res.answer = entry_status[idx] == sbpb_pkg::ST_WAIT;
            end
            sbpb_pkg::OP_CLEAR_ALL: begin
               foreach (entry_status[i]) begin
                  entry_status[i] = sbpb_pkg::ST_NOVAL;
                  entry_seen[i]   = 1'b0;
               end
            end
            sbpb_pkg::OP_READ_PORTS: begin
               if (want > rd_ports_set || now < rd_stamp) begin
                  res.error = 1'b1;
               end else if (now > rd_stamp) begin
                  rd_budget  = int'(rd_ports_set) - int'(want);
                  rd_stamp   = now;
                  res.answer = 1'b1;
               end else begin
                  rd_budget = rd_budget - int'(want);
                  if (rd_budget < RD_FLOOR) rd_budget = RD_FLOOR;
                  res.answer = rd_budget >= 0;
               end
            end
            sbpb_pkg::OP_WRITE_PORT: begin
               if (now < wr_stamp) begin
                  res.error = 1'b1;
               end else if (now > wr_stamp) begin
                  wr_budget  = wr_ports_set;
                  wr_stamp   = now;
                  res.answer = 1'b1;
               end else begin
                  if (wr_budget != 0) wr_budget = wr_budget - 1'b1;
                  res.answer = wr_budget != 0;
               end
            end
            default: ;
         endcase
      end
      return res;
   endfunction

   // any register number and any port request
   function automatic logic [sbpb_pkg::REG_W-1:0] any_reg();
      return sbpb_pkg::REG_W'($urandom_range(0, REG_MAX));
   endfunction

   function automatic logic [sbpb_pkg::WANT_W-1:0] any_want();
      return sbpb_pkg::WANT_W'($urandom_range(0, 15));
   endfunction

   // read ports up to the programmed count
   function automatic logic [sbpb_pkg::WANT_W-1:0] want_in_budget();
      return sbpb_pkg::WANT_W'($urandom_range(0, int'(rd_ports_set)));
   endfunction

   // cycle number for a budget request: mostly the same or the next cycle,
   // sometimes a jump ahead, sometimes a cycle already gone
   function automatic logic [sbpb_pkg::NOW_W-1:0] pick_now();
      int roll;
      int back;
      roll = $urandom_range(0, 99);
      if (roll < 3) return $urandom;
      if (roll < 12 && cur_cycle > 0) begin
         back = $urandom_range(1, (cur_cycle > 5000) ? 5000 : int'(cur_cycle));
         return sbpb_pkg::NOW_W'(cur_cycle - back);
      end
      if (roll < 50) cur_cycle = cur_cycle + 1;
      else if (roll < 58) cur_cycle = cur_cycle + $urandom_range(2, 70000);
      if (cur_cycle > 64'hFFFF_FFFF) cur_cycle = 64'hFFFF_FFFF;
      return sbpb_pkg::NOW_W'(cur_cycle);
   endfunction

   // register number: mostly inside the window, crowded on a few hot entries
   function automatic logic [sbpb_pkg::REG_W-1:0] pick_reg();
      int span;
      int roll;
      span = REG_MAX - int'(base_reg);
      if (span > NUM_REGS - 1) span = NUM_REGS - 1;
      roll = $urandom_range(0, 99);
      if (roll < 12) return any_reg();
      if (roll < 50)
         return sbpb_pkg::REG_W'(int'(base_reg) + $urandom_range(0, (span < 3) ? span : 3));
      if (roll < 56) return sbpb_pkg::REG_W'(int'(base_reg) + span);
      return sbpb_pkg::REG_W'(int'(base_reg) + $urandom_range(0, span));
   endfunction

   // one request beat, entered and left at a falling edge; may idle afterwards
   task automatic drive_beat(input logic [sbpb_pkg::OP_W-1:0] op,
                             input logic [sbpb_pkg::REG_W-1:0] reg_num,
                             input logic [sbpb_pkg::NOW_W-1:0] now,
                             input logic [sbpb_pkg::WANT_W-1:0] want,
                             input bit fixed, input sbpb_pkg::budget_res_type fixed_res);
      int gap;
      req_tvalid   <= 1'b1;
      req_tuser    <= op;
      req_tdata    <= {2'b00, want, now, reg_num};
      row_fixed     = fixed;
      row_fixed_res = fixed_res;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (op != OP_UNUSED) beats_sent++;
      gap = 0;
      if (gaps_on) begin
         if (calm_tx != 0) calm_tx--;
         else if ($urandom_range(0, 49) == 0) calm_tx = $urandom_range(30, 120);
         else if ($urandom_range(0, 6) == 0) gap = $urandom_range(1, 14);
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send(input logic [sbpb_pkg::OP_W-1:0] op,
                       input logic [sbpb_pkg::REG_W-1:0] reg_num,
                       input logic [sbpb_pkg::NOW_W-1:0] now,
                       input logic [sbpb_pkg::WANT_W-1:0] want);
      drive_beat(op, reg_num, now, want, 1'b0, '0);
   endtask

   // write one register, read it back, then follow it in the shadow
   task automatic set_register(input logic [1:0] idx,
                               input logic [sbpb_pkg::CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value) begin
         fail_count++;
         $display("%0t: register %0d read back expected %0h actual %0h",
                  $time, idx, value, csr_prdata);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         sbpb_pkg::CSR_FIRST_REG:   base_reg     = value[sbpb_pkg::REG_W-1:0];
         sbpb_pkg::CSR_READ_PORTS:  rd_ports_set = value[sbpb_pkg::PORTS_W-1:0];
         sbpb_pkg::CSR_WRITE_PORTS: wr_ports_set = value[sbpb_pkg::PORTS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // random traffic until the beat count reaches target
   task automatic run_random(input int target);
      int kind;
      int count;
      logic [sbpb_pkg::REG_W-1:0] r;
      while (beats_sent < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            // register lifecycle: reserve at issue, writeback, queries in between
            r = pick_reg();
            send(sbpb_pkg::OP_RESERVE, r, $urandom, any_want());
            if ($urandom_range(0, 1)) send(sbpb_pkg::OP_QUERY_BUSY, r, $urandom, any_want());
            if ($urandom_range(0, 2) == 0)
               send(sbpb_pkg::OP_QUERY_VALID, r, $urandom, any_want());
            if ($urandom_range(0, 9) != 0)
               send(sbpb_pkg::OP_MARK_DONE, r, $urandom, any_want());
            if ($urandom_range(0, 1)) send(sbpb_pkg::OP_QUERY_VALID, r, $urandom, any_want());
            if ($urandom_range(0, 2) == 0)
               send(sbpb_pkg::OP_QUERY_BUSY, r, $urandom, any_want());
         end else if (kind < 60) begin
            send(sbpb_pkg::OP_W'($urandom_range(sbpb_pkg::OP_RESERVE, sbpb_pkg::OP_QUERY_BUSY)),
                 pick_reg(), $urandom, any_want());
         end else if (kind < 82) begin
            // short run of port requests around the current cycle
            count = $urandom_range(1, 6);
            repeat (count) begin
               if ($urandom_range(0, 1))
                  send(sbpb_pkg::OP_READ_PORTS, any_reg(), pick_now(),
                       ($urandom_range(0, 4) != 0) ? want_in_budget() : any_want());
               else
                  send(sbpb_pkg::OP_WRITE_PORT, any_reg(), pick_now(), any_want());
            end
         end else if (kind < 86) begin
            // many requests in one cycle, drives the read budget to its floor
            if (cur_cycle < 64'hFFFF_FFFF) cur_cycle = cur_cycle + 1;
            count = $urandom_range(18, 26);
            repeat (count) begin
               if ($urandom_range(0, 3) == 0)
                  send(sbpb_pkg::OP_WRITE_PORT, any_reg(), sbpb_pkg::NOW_W'(cur_cycle),
                       any_want());
               else
                  send(sbpb_pkg::OP_READ_PORTS, any_reg(), sbpb_pkg::NOW_W'(cur_cycle),
                       ($urandom_range(0, 3) != 0) ? rd_ports_set : want_in_budget());
            end
         end else if (kind < 88) begin
            send(sbpb_pkg::OP_CLEAR_ALL, any_reg(), $urandom, any_want());
         end else if (kind < 90) begin
            send(OP_UNUSED, any_reg(), $urandom, any_want());
         end else begin
            // noise: any code, any fields
            send(sbpb_pkg::OP_W'($urandom_range(0, 7)), any_reg(), $urandom, any_want());
         end
      end
   endtask

   // settle the block, reprogram every register, then run random traffic
   task automatic run_phase(input int first, input int rports, input int wports,
                            input longint now_base, input int items, input bit idling);
      req_tvalid <= 1'b0;
      while (owed_outcomes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      set_register(sbpb_pkg::CSR_FIRST_REG, first);
      set_register(sbpb_pkg::CSR_READ_PORTS, rports);
      set_register(sbpb_pkg::CSR_WRITE_PORTS, wports);
      settings_used++;
      @(posedge clock);
      gaps_on = idling;
      @(negedge clock);
      if (cur_cycle < now_base) cur_cycle = now_base;
      run_random(beats_sent + items);
   endtask

   // response side: ready with random stall bursts, calm stretches between
   always @(negedge clock) begin
      if (!gaps_on) begin
         stall_rx = 0;
      end else if (stall_rx != 0) begin
         stall_rx--;
      end else if (calm_rx != 0) begin
         calm_rx--;
      end else if ($urandom_range(0, 59) == 0) begin
         calm_rx = $urandom_range(40, 200);
      end else if ($urandom_range(0, 5) == 0) begin
         stall_rx = $urandom_range(1, 14);
      end
      rsp_tready <= (stall_rx == 0);
   end

   // at each rising edge: predict accepted request beats, check accepted response beats
   always @(posedge clock) begin
      sbpb_pkg::budget_res_type owed;
      sbpb_pkg::budget_res_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            owed = scoreboard_outcome(req_tuser, req_tdata[9:0], req_tdata[41:10],
                                      req_tdata[45:42]);
            // a directed row checks against its typed-in outcome
            if (row_fixed) owed = row_fixed_res;
            owed_outcomes.push_back(owed);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.answer = rsp_tdata[0];
            got.error  = rsp_tuser;
            if (got.answer === 1'b1) grants_seen++;
            if (got.error === 1'b1) errors_seen++;
            if (owed_outcomes.size() == 0) begin
               fail_count++;
               $display("%0t: response beat with nothing owed, answer %0b error %0b",
                        $time, got.answer, got.error);
            end else begin
               owed = owed_outcomes.pop_front();
               beats_checked++;
               if (got.answer !== owed.answer) begin
                  fail_count++;
                  $display("%0t: answer expected %0b actual %0b",
                           $time, owed.answer, got.answer);
               end
               if (got.error !== owed.error) begin
                  fail_count++;
                  $display("%0t: error expected %0b actual %0b",
                           $time, owed.error, got.error);
               end
            end
         end
         // watchdog: no beat and no register access for too long
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
               $display("FAIL register_scoreboard_with_port_budget");
               $finish;
            end
         end
      end
   end

   initial begin
      foreach (entry_status[i]) begin
         entry_status[i] = sbpb_pkg::ST_NOVAL;
         entry_seen[i]   = 1'b0;
      end
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table at the reset register values
      foreach (DIRECTED_ROWS[i])
         drive_beat(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].reg_num, DIRECTED_ROWS[i].now,
                    DIRECTED_ROWS[i].want, DIRECTED_ROWS[i].fixed,
                    '{answer: DIRECTED_ROWS[i].answer, error: DIRECTED_ROWS[i].error});
      cur_cycle = 7;

      // settings from reset values through both extremes; the stamp base climbs
      // so every bit of the cycle number is seen at both values
      run_phase(0, 2, 1, 64'h0, 280, 1'b1);
      run_phase(REG_MAX, 8, 8, 64'h0000_5A5A, 260, 1'b1);
      run_phase(960, 1, 1, 64'h3FFF_FFF0, 260, 1'b1);
      run_phase($urandom_range(0, REG_MAX), $urandom_range(1, 8), $urandom_range(1, 8),
                64'h7FFF_0000, 280, 1'b1);
      run_phase(0, 8, 1, 64'h8000_0000, 280, 1'b1);
      // last stretch runs at full rate on both sides
      run_phase($urandom_range(0, REG_MAX), $urandom_range(1, 8), $urandom_range(1, 8),
                64'hFFFF_0000, 300, 1'b0);

      // top cycle number, then one just under it is stale for the read budget
      send(sbpb_pkg::OP_WRITE_PORT, '0, 32'hFFFF_FFFF, '0);
      send(sbpb_pkg::OP_READ_PORTS, '0, 32'hFFFF_FFFF, rd_ports_set);
      send(sbpb_pkg::OP_READ_PORTS, '0, 32'hFFFF_FFFE, '0);
      req_tvalid <= 1'b0;

      while (owed_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d request beats over %0d register settings, %0d responses checked",
               beats_sent, settings_used + 1, beats_checked);
      $display("responses granting a port or valid/busy: %0d, responses with error: %0d",
               grants_seen, errors_seen);
      if (fail_count == 0) begin
         $display("PASS register_scoreboard_with_port_budget");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("FAIL register_scoreboard_with_port_budget");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
sv/sbpb_pkg.sv
sv/sbpb_table.sv
sv/sbpb_budget.sv
sv/register_scoreboard_with_port_budget.sv
test/tb_register_scoreboard_with_port_budget.sv
